[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies a property in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition implies a property in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/tgarle_pkg.sv]
// ----------------------------------------------------------------------------
// tgarle_pkg
// Types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd1;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXEL  = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [7:0] HDR_RUN_MASK = 8'h80;
    localparam logic [7:0] HDR_LEN_MASK = 8'h7F;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        image_last;
    } result_t;

endpackage

[sv/tgarle_in_stage.sv]
// ----------------------------------------------------------------------------
// tgarle_in_stage
// Input register: captures one transaction whenever the stage is not stalled.
// ----------------------------------------------------------------------------
module tgarle_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  tgarle_pkg::item_t   item,
    output logic                s1_valid,
    output tgarle_pkg::item_t   s1_item
);
    import tgarle_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            item_reg <= item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

[sv/tgarle_core.sv]
// ----------------------------------------------------------------------------
// tgarle_core
// Configuration registers, decode state and the per-byte decode logic.
// ----------------------------------------------------------------------------
module tgarle_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tgarle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 item_fire,
    input  tgarle_pkg::item_t                    s1_item,
    output logic                                 res_valid,
    output tgarle_pkg::result_t                  res,
    output logic [1:0]                           phase
);
    import tgarle_pkg::*;

    logic [2:0]  bpp_reg;
    logic [31:0] total_reg;

    logic [1:0]  phase_reg,    phase_next;
    logic [7:0]  pkt_rem_reg,  pkt_rem_next;
    logic        is_run_reg,   is_run_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [31:0] asm_reg,      asm_next;
    logic [31:0] done_reg,     done_next;

    logic [2:0]  bpp_eff;
    logic [1:0]  pos;
    logic [31:0] asm_or;
    logic        last_byte;
    logic [31:0] total_eff;
    logic [31:0] remain;
    logic [7:0]  cnt_raw;
    logic [7:0]  cnt;
    logic        last;
    logic [7:0]  pkt_rem_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= 3'd1;
            total_reg <= 32'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BPP:   bpp_reg   <= cfg_data[2:0];
                CFG_TOTAL: total_reg <= cfg_data[31:0];
                default:   ;
            endcase
        end
    end

    // Datapath helpers
    always_comb
    begin
        case (bpp_reg)
            3'd0:    bpp_eff = 3'd1;
            3'd1:    bpp_eff = 3'd1;
            3'd2:    bpp_eff = 3'd2;
            3'd3:    bpp_eff = 3'd3;
            default: bpp_eff = 3'd4;
        endcase

        // three-byte pixels swap first and third bytes
        pos = byte_idx_reg;
        if (bpp_eff == 3'd3 && byte_idx_reg != 2'd3)
        begin
            pos = 2'd2 - byte_idx_reg;
        end
        asm_or    = asm_reg | ({24'd0, s1_item.data_byte} << {pos, 3'b000});
        last_byte = ({1'b0, byte_idx_reg} + 3'd1) >= bpp_eff;

        total_eff = (total_reg == 32'd0) ? 32'd1 : total_reg;
        remain    = (total_eff > done_reg) ? (total_eff - done_reg) : 32'd1;

        if (is_run_reg)
        begin
            cnt_raw       = (pkt_rem_reg == 8'd0) ? 8'd1 : pkt_rem_reg;
            pkt_rem_after = 8'd0;
        end
        else
        begin
            cnt_raw       = 8'd1;
            pkt_rem_after = (pkt_rem_reg != 8'd0) ? (pkt_rem_reg - 8'd1) : 8'd0;
        end
        cnt  = (remain < {24'd0, cnt_raw}) ? remain[7:0] : cnt_raw;
        // count equal to what remains is exactly the image end
        last = ({24'd0, cnt} == remain);
    end

    // State update
    always_comb
    begin
        phase_next    = phase_reg;
        pkt_rem_next  = pkt_rem_reg;
        is_run_next   = is_run_reg;
        byte_idx_next = byte_idx_reg;
        asm_next      = asm_reg;
        done_next     = done_reg;
        res_valid     = 1'b0;

        if (s1_item.kind == KIND_START)
        begin
            phase_next    = PH_HEADER;
            pkt_rem_next  = 8'd0;
            is_run_next   = 1'b0;
            byte_idx_next = 2'd0;
            asm_next      = 32'd0;
            done_next     = 32'd0;
        end
        else if (phase_reg == PH_HEADER)
        begin
            is_run_next   = (s1_item.data_byte & HDR_RUN_MASK) != 8'd0;
            pkt_rem_next  = (s1_item.data_byte & HDR_LEN_MASK) + 8'd1;
            byte_idx_next = 2'd0;
            asm_next      = 32'd0;
            phase_next    = PH_PIXEL;
        end
        else if (phase_reg == PH_PIXEL)
        begin
            if (!last_byte)
            begin
                asm_next      = asm_or;
                byte_idx_next = byte_idx_reg + 2'd1;
            end
            else
            begin
                res_valid     = 1'b1;
                pkt_rem_next  = pkt_rem_after;
                done_next     = done_reg + {24'd0, cnt};
                byte_idx_next = 2'd0;
                asm_next      = 32'd0;
                if (last)
                begin
                    phase_next = PH_DONE;
                end
                else if (pkt_rem_after == 8'd0)
                begin
                    phase_next = PH_HEADER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pkt_rem_reg  <= 8'd0;
            is_run_reg   <= 1'b0;
            byte_idx_reg <= 2'd0;
            asm_reg      <= 32'd0;
            done_reg     <= 32'd0;
        end
        else if (item_fire)
        begin
            phase_reg    <= phase_next;
            pkt_rem_reg  <= pkt_rem_next;
            is_run_reg   <= is_run_next;
            byte_idx_reg <= byte_idx_next;
            asm_reg      <= asm_next;
            done_reg     <= done_next;
        end
    end

    assign res.pixel_value  = asm_or;
    assign res.repeat_count = cnt;
    assign res.image_last   = last;
    assign phase            = phase_reg;

endmodule

[sv/tgarle_out_reg.sv]
// ----------------------------------------------------------------------------
// tgarle_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module tgarle_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_load,
    input  tgarle_pkg::result_t   res,
    input  logic                  result_stall,
    output logic                  result_valid,
    output tgarle_pkg::result_t   result,
    output logic                  out_ready
);
    import tgarle_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign out_ready = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

[sv/tga_rle_pixel_decoder_top.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// TGA run-length decoder: one stream byte in, at most one pixel result out.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item (kind, data_byte). A
//                    transaction is taken at a clock edge with valid high and
//                    stall low. kind = start clears decode state.
//   result channel : result_valid / result_stall / result (pixel_value,
//                    repeat_count, image_last). A run comes out as one result
//                    with its repeat count, clipped to the pixels left.
//   config port    : cfg_wr_en / cfg_index / cfg_data, index 0 = pixel size,
//                    1 = pixel total. Write only while the block is idle.
// Result path: the byte that finishes a pixel passes the input register,
//   then the result register.
// Throughput: one byte per cycle while no result is held up by a receiver
//   stall; set by the state update between the input and result registers.
// Reset: pixel size 1, total 1, decoder waiting for a packet header.
// Receiver stall: the result register holds; the input register keeps
//   accepting bytes that give no result, and stalls only when its byte would
//   produce a result that has nowhere to go.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tga_rle_pixel_decoder_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tgarle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  tgarle_pkg::item_t                    item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output tgarle_pkg::result_t                  result
);
    import tgarle_pkg::*;

    logic    s1_valid;
    item_t   s1_item;
    logic    res_valid;
    result_t res;
    logic    out_ready;
    logic    s1_adv;
    logic    res_load;
    logic [1:0] phase;

    // A byte leaves the input register unless its result cannot be parked.
    assign s1_adv     = s1_valid && (out_ready || !res_valid);
    assign res_load   = s1_adv && res_valid;
    assign item_stall = s1_valid && !s1_adv;

    tgarle_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    tgarle_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_fire (s1_adv),
        .s1_item   (s1_item),
        .res_valid (res_valid),
        .res       (res),
        .phase     (phase)
    );

    tgarle_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_load     (res_load),
        .res          (res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .out_ready    (out_ready)
    );

    // The final pixel of an image parks the decoder in the done phase.
    `ASSERT_NEXT(a_last_to_done, clk, rst_n, res_load && res.image_last, phase == PH_DONE)
    // Nothing is produced once the image is complete.
    `ASSERT_SAME(a_done_silent, clk, rst_n, phase == PH_DONE, !res_valid)
    // Repeat counts stay within one run packet.
    `ASSERT_SAME(a_count_range, clk, rst_n, result_valid,
        result.repeat_count != 8'd0 && result.repeat_count <= 8'd128)
    // Input stalls only on a held byte.
    `ASSERT_SAME(a_stall_held, clk, rst_n, item_stall, s1_valid && res_valid && !out_ready)

endmodule

[test/tga_rle_pixel_decoder_top_tb.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top_tb
// Self-checking bench for the TGA run-length pixel decoder. A cycle-free model
// of the packet decoder predicts every pixel result as stream bytes are taken.
// The DUT output is compared against that prediction in order. Directed
// sequences come first, then randomized packet streams under several settings
// of pixel size and pixel total. Both channels idle at random.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tgarle_pkg::*;

    localparam int     SETTLE_CYCLES = 6;        // result path is two registers deep
    localparam int     RANDOM_BYTES  = 600;      // decoded bytes in the random part
    localparam int     LONG_HOLD     = 300;      // receiver hold-off, in cycles
    localparam int     MAX_REPORTS   = 10;
    localparam longint LIMIT_NS      = 3_200_000;

    // ------------------------------------------------------------------------
    // Pixel prediction and in-order checking
    // ------------------------------------------------------------------------
    class tga_pixel_checker;
        logic [2:0]  pix_size_reg;
        logic [31:0] pix_total_reg;
        logic [1:0]  phase;
        logic [7:0]  pkt_left;
        logic        pkt_run;
        logic [1:0]  byte_idx;
        logic [31:0] assembly;
        logic [31:0] pixels_done;
        result_t     pending_pixels[$];
        int unsigned decoded_bytes;
        int unsigned checked_pixels;
        int unsigned run_pixels;
        int unsigned literal_pixels;
        int unsigned errors;

        function new();
            pix_size_reg  = 3'd1;
            pix_total_reg = 32'd1;
            restart();
        endfunction

        function void restart();
            phase       = PH_HEADER;
            pkt_left    = '0;
            pkt_run     = 1'b0;
            byte_idx    = '0;
            assembly    = '0;
            pixels_done = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_BPP)
                pix_size_reg = data[2:0];
            else if (idx == CFG_TOTAL)
                pix_total_reg = data;
        endfunction

        // 0 behaves as 1, anything past 4 as 4
        function int unsigned pixel_bytes();
            if (pix_size_reg == 3'd0)
                return 1;
            if (pix_size_reg > 3'd4)
                return 4;
            return pix_size_reg;
        endfunction

        function bit image_done();
            return phase == PH_DONE;
        endfunction

        function void take_byte(item_t it);
            int unsigned size;
            int unsigned pos;
            logic [31:0] total;
            logic [31:0] remain;
            logic [31:0] count;
            logic        last;
            result_t     want;

            if (it.kind == KIND_START)
            begin
                restart();
                decoded_bytes++;
                return;
            end
            if (phase == PH_HEADER)
            begin
                pkt_run  = (it.data_byte & HDR_RUN_MASK) != 8'h00;
                pkt_left = (it.data_byte & HDR_LEN_MASK) + 8'd1;
                byte_idx = '0;
                assembly = '0;
                phase    = PH_PIXEL;
                decoded_bytes++;
                return;
            end
            if (phase != PH_PIXEL)
                return;          // image complete, byte dropped
            decoded_bytes++;

            size = pixel_bytes();
            pos  = byte_idx;
            // three-byte pixels are stored with first and third bytes swapped
            if (size == 3 && pos <= 2)
                pos = 2 - pos;
            assembly = assembly | (32'(it.data_byte) << (8 * pos));
            if (int'(byte_idx) + 1 < size)
            begin
                byte_idx = byte_idx + 2'd1;
                return;
            end

            total  = (pix_total_reg == 32'd0) ? 32'd1 : pix_total_reg;
            remain = (total > pixels_done) ? total - pixels_done : 32'd1;
            if (pkt_run)
            begin
                count    = (pkt_left == 8'd0) ? 32'd1 : 32'(pkt_left);
                pkt_left = '0;
                run_pixels++;
            end
            else
            begin
                count    = 32'd1;
                pkt_left = (pkt_left > 8'd0) ? pkt_left - 8'd1 : 8'd0;
                literal_pixels++;
            end
            if (count > remain)
                count = remain;
            pixels_done = pixels_done + count;
            last = (pixels_done >= total) || (count == remain);

            want.pixel_value  = assembly;
            want.repeat_count = count[7:0];
            want.image_last   = last;
            pending_pixels.push_back(want);

            byte_idx = '0;
            assembly = '0;
            if (last)
                phase = PH_DONE;
            else if (pkt_left == 8'd0)
                phase = PH_HEADER;
        endfunction

        function void check_pixel(result_t got);
            result_t want;

            if (pending_pixels.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected pixel value=%h count=%0d last=%b", $realtime,
                             got.pixel_value, got.repeat_count, got.image_last);
                return;
            end
            want = pending_pixels.pop_front();
            checked_pixels++;
            if (got.pixel_value !== want.pixel_value || got.repeat_count !== want.repeat_count
                || got.image_last !== want.image_last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: pixel %0d exp value=%h count=%0d last=%b, got %h/%0d/%b",
                             $realtime, checked_pixels, want.pixel_value, want.repeat_count,
                             want.image_last, got.pixel_value, got.repeat_count,
                             got.image_last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and bench state
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;

    tga_pixel_checker sb = new();

    bit          tx_idle_on;           // sender inserts gaps
    bit          rx_idle_on;           // receiver inserts stalls
    int          rx_hold_cycles;       // one-shot long hold-off request
    int unsigned input_stall_cycles;
    int unsigned image_setups;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tga_rle_pixel_decoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int idle_len(bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus tasks. Every task returns in the time step of the edge that
    // took the last transaction, so the next payload goes out in that same
    // step and valid stays high across back-to-back transactions.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [7:0] data);
        int gap;
        gap = idle_len(tx_idle_on);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{kind: kind, data_byte: data};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // accepted at this edge: advance the prediction
        sb.take_byte(item);
    endtask

    // Sender stops and waits for every predicted pixel to come out.
    task automatic wait_results();
        item_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only once the pipe is empty; bytes that give no pixel
    // may still be in flight, so let the pipe settle first.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_wr_en <= 1'b0;
    endtask

    // One packet: header, then its pixel bytes. A few packets get cut short,
    // pick up a stray byte, or get interrupted by a start transaction.
    task automatic send_packet();
        int unsigned len;
        int unsigned nbytes;
        int unsigned r;
        logic        run;

        r   = $urandom_range(0, 99);
        len = (r < 92) ? $urandom_range(0, 7) : $urandom_range(8, 127);
        run = 1'($urandom_range(0, 1));
        send_item(KIND_DATA, {run, 7'(len)});
        nbytes = (run ? 1 : len + 1) * sb.pixel_bytes();
        if ($urandom_range(0, 99) < 4)
            nbytes = $urandom_range(0, nbytes - 1);
        for (int i = 0; i < nbytes; i++)
        begin
            r = $urandom_range(0, 299);
            if (r == 0)
                send_item(KIND_START, 8'($urandom));
            else if (r < 5)
                send_item(KIND_DATA, 8'($urandom));
            send_item(KIND_DATA, 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall stretches, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n              = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                n = idle_len(rx_idle_on);
            end
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Result monitor and input stall counter
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_pixel(result);
        if (rst_n && item_valid && item_stall)
            input_stall_cycles++;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned target;
        int unsigned r;
        int unsigned packets;
        logic [31:0] total;

        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // Reset settings: one-byte pixels, one-pixel image.
        send_item(KIND_DATA, 8'h00);          // literal, one pixel
        send_item(KIND_DATA, 8'hFF);          // completes the image
        send_item(KIND_DATA, 8'h55);          // dropped, image done

        // Three-byte pixels, zero total acts as one; a run of six clips to one.
        write_reg(CFG_BPP, 32'd3);
        write_reg(CFG_TOTAL, 32'd0);
        send_item(KIND_START, 8'hA5);         // start ignores its data byte
        send_item(KIND_DATA, 8'h85);
        send_item(KIND_DATA, 8'h11);
        send_item(KIND_DATA, 8'h22);
        send_item(KIND_DATA, 8'h33);

        // Literal of two; the pixel size drops to two in the middle of a pixel.
        write_reg(CFG_TOTAL, 32'd10);
        send_item(KIND_START, 8'h00);
        send_item(KIND_DATA, 8'h01);
        send_item(KIND_DATA, 8'hA1);
        send_item(KIND_DATA, 8'hB2);
        write_reg(CFG_BPP, 32'd2);
        send_item(KIND_DATA, 8'hC3);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'h80);

        // Total lowered below the pixels already done: next pixel ends image.
        write_reg(CFG_TOTAL, 32'd1);
        send_item(KIND_DATA, 8'h90);
        send_item(KIND_DATA, 8'h34);
        send_item(KIND_DATA, 8'h12);

        // Oversized pixel setting acts as four bytes; longest run, top total.
        write_reg(CFG_BPP, 32'd7);
        write_reg(CFG_TOTAL, 32'hFFFF_FFFF);
        send_item(KIND_START, 8'hFF);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h01);
        send_item(KIND_DATA, 8'h02);
        send_item(KIND_DATA, 8'h03);
        send_item(KIND_DATA, 8'h04);

        // --- back-pressure: receiver holds off while the sender keeps going ---
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_reg(CFG_BPP, 32'd1);
        write_reg(CFG_TOTAL, 32'd1000);
        rx_hold_cycles = LONG_HOLD;
        repeat (2) @(posedge clk);
        send_item(KIND_START, 8'h00);
        send_item(KIND_DATA, 8'h3F);          // literal of 64 one-byte pixels
        repeat (64) send_item(KIND_DATA, 8'($urandom));
        wait_results();                       // sender pauses for a full drain
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // --- random images ---
        target = sb.decoded_bytes + RANDOM_BYTES;
        while (sb.decoded_bytes < target)
        begin
            image_setups++;
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);

            r = $urandom_range(0, 99);
            if (r < 80)
                write_reg(CFG_BPP, $urandom_range(1, 4));
            else if (r < 95)
                write_reg(CFG_BPP, $urandom_range(0, 7));

            r = $urandom_range(0, 99);
            if (r < 60)
                total = $urandom_range(1, 24);
            else if (r < 80)
                total = $urandom_range(25, 200);
            else if (r < 86)
                total = 32'd0;
            else if (r < 92)
                total = 32'd1;
            else if (r < 96)
                total = 32'hFFFF_FFFF;
            else
                total = $urandom();
            if ($urandom_range(0, 9) != 0)
                write_reg(CFG_TOTAL, total);

            send_item(KIND_START, 8'($urandom));
            packets = $urandom_range(2, 14);
            while (packets > 0 && !sb.image_done())
            begin
                send_packet();
                packets--;
            end
            // trailing bytes after the image is complete are dropped
            if (sb.image_done())
                repeat ($urandom_range(0, 2)) send_item(KIND_DATA, 8'($urandom));
        end

        // --- wrap-up ---
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_pixels.size() != 0)
            $display("%0d predicted pixels never came out", sb.pending_pixels.size());

        $display("Covered %0d random image setups, %0d decoded stream bytes, %0d pixels",
                 image_setups, sb.decoded_bytes, sb.checked_pixels);
        $display("  (%0d runs, %0d literal pixels); input held off for %0d cycles",
                 sb.run_pixels, sb.literal_pixels, input_stall_cycles);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop in case the decoder hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("Run limit reached with %0d pixels outstanding", sb.pending_pixels.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/tgarle_pkg.sv
sv/tgarle_in_stage.sv
sv/tgarle_core.sv
sv/tgarle_out_reg.sv
sv/tga_rle_pixel_decoder_top.sv
test/tga_rle_pixel_decoder_top_tb.sv
